// File: src/ppmfd_pkg.sv
// Package for the PPM frame decoder: channel count, field widths and
// configuration register indexes. No dependencies.
package ppmfd_pkg;

	localparam int NUM_CHANNELS = 6;
	localparam int OUT_CHANS    = 6;
	localparam int SLOT_SAT     = NUM_CHANNELS + 1;
	localparam int SLOT_W       = $clog2(SLOT_SAT + 1);

	localparam int TIME_W  = 32;
	localparam int CHAN_W  = 16;
	localparam int SYNC_W  = 16;
	localparam int STALE_W = 24;
	localparam int CFG_W   = 24;

	localparam int IN_BITS  = 1 + TIME_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = OUT_CHANS * CHAN_W + 2;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [15:0] SYNC_GAP_RESET  = 16'd5000;
	localparam logic [23:0] STALE_TIMEOUT_RESET = 24'd500000;

	typedef enum logic [0:0] {
		REG_SYNC_GAP      = 1'b0,
		REG_STALE_TIMEOUT = 1'b1
	} cfg_reg_t;

	typedef logic [CHAN_W-1:0] chan_t;

endpackage

// File: src/ppm_frame_decoder_core.sv
// Top level of the PPM frame decoder: input register, edge decode with the
// slot counter and channel store, and the result register.
// Depends on ppmfd_pkg.
//
//  channel   direction  handshake         payload
//  s_*       in         tvalid / tready   tdata: pin_level, time_us
//  m_*       out        tvalid / tready   tdata: chan0_us..chan5_us, frame_done, frame_fresh
//  cfg_*     in         cfg_we            cfg_addr, cfg_wdata
//
// One transaction per clock is sustained while the output is not stalled; a pin change
// passes through the input register, then the result register, to the output. The only
// loop is the interval subtract and sync compare that updates the slot counter.
// Reset clears the slot counter, timestamps, channel store and both valid flags
// and loads the register defaults. A stalled output holds its result while the
// input register may still take one more transaction.
module ppm_frame_decoder_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [0] pin_level, [32:1] time_us, rest zero
	input  logic [ppmfd_pkg::IN_W-1:0]     s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [15:0] chan0_us .. [95:80] chan5_us, [96] frame_done, [97] frame_fresh
	output logic [ppmfd_pkg::OUT_W-1:0]    m_tdata,
	input  logic                           cfg_we,
	input  logic                           cfg_addr,
	input  logic [ppmfd_pkg::CFG_W-1:0]    cfg_wdata
);

	localparam int NCH = ppmfd_pkg::NUM_CHANNELS;
	localparam int TW  = ppmfd_pkg::TIME_W;
	localparam int SW  = ppmfd_pkg::SLOT_W;

	logic [ppmfd_pkg::SYNC_W-1:0]  sync_gap_q;
	logic [ppmfd_pkg::STALE_W-1:0] stale_timeout_q;

	logic          valid_s1;
	logic          level_s1;
	logic [TW-1:0] time_s1;

	logic [TW-1:0] prev_rise_q;
	logic [TW-1:0] frame_time_q;
	logic [SW-1:0] slot_q;
	ppmfd_pkg::chan_t chan_q [NCH];

	logic          out_valid_q;
	logic          done_q;
	logic          fresh_q;
	ppmfd_pkg::chan_t out_chan_q [NCH];

	logic          advance;
	logic          process;
	logic [TW-1:0] dt;
	logic [TW-1:0] age;
	logic          is_sync;
	logic          done_c;
	logic          fresh_c;
	logic [SW-1:0] slot_next;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign process  = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_gap_q      <= ppmfd_pkg::SYNC_GAP_RESET;
			stale_timeout_q <= ppmfd_pkg::STALE_TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (ppmfd_pkg::cfg_reg_t'(cfg_addr))
				ppmfd_pkg::REG_SYNC_GAP:      sync_gap_q <= cfg_wdata[ppmfd_pkg::SYNC_W-1:0];
				ppmfd_pkg::REG_STALE_TIMEOUT: stale_timeout_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			level_s1 <= s_tdata[0];
			time_s1  <= s_tdata[TW:1];
		end
	end

	// Edge decode.
	always_comb begin
		dt      = time_s1 - prev_rise_q;
		is_sync = dt > TW'(sync_gap_q);
		age     = time_s1 - frame_time_q;
		done_c  = level_s1 && !is_sync && (slot_q == SW'(NCH));
		// A completed frame stamps this edge, so its age is zero.
		fresh_c = done_c || (age <= TW'(stale_timeout_q));
		if (is_sync) begin
			slot_next = SW'(1);
		end else if (slot_q < SW'(ppmfd_pkg::SLOT_SAT)) begin
			slot_next = slot_q + SW'(1);
		end else begin
			slot_next = slot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_rise_q  <= '0;
			frame_time_q <= '0;
			slot_q       <= '0;
			for (int k = 0; k < NCH; k++) begin
				chan_q[k] <= '0;
			end
		end else if (process && level_s1) begin
			prev_rise_q <= time_s1;
			slot_q      <= slot_next;
			if (done_c) begin
				frame_time_q <= time_s1;
			end
			for (int k = 0; k < NCH; k++) begin
				if (!is_sync && slot_q == SW'(k + 1)) begin
					chan_q[k] <= dt[ppmfd_pkg::CHAN_W-1:0];
				end
			end
		end
	end

	// Result register; the channel values shown are those after this edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			done_q  <= done_c;
			fresh_q <= fresh_c;
			for (int k = 0; k < NCH; k++) begin
				if (level_s1 && !is_sync && slot_q == SW'(k + 1)) begin
					out_chan_q[k] <= dt[ppmfd_pkg::CHAN_W-1:0];
				end else begin
					out_chan_q[k] <= chan_q[k];
				end
			end
		end
	end

	assign m_tvalid = out_valid_q;

	always_comb begin
		m_tdata = '0;
		for (int j = 0; j < ppmfd_pkg::OUT_CHANS; j++) begin
			if (j < NCH) begin
				m_tdata[j*ppmfd_pkg::CHAN_W +: ppmfd_pkg::CHAN_W] = out_chan_q[j];
			end
		end
		m_tdata[ppmfd_pkg::OUT_CHANS*ppmfd_pkg::CHAN_W]     = done_q;
		m_tdata[ppmfd_pkg::OUT_CHANS*ppmfd_pkg::CHAN_W + 1] = fresh_q;
	end

	// The slot counter never passes its saturation value.
	assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SW'(ppmfd_pkg::SLOT_SAT))
		else $error("slot counter above saturation");

	// A frame that just completed is always fresh.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_q |-> fresh_q)
		else $error("completed frame reported stale");

	// Completing a frame leaves the counter saturated and stamps the frame time.
	assert property (@(posedge clk) disable iff (!arst_n)
		process && done_c |=> slot_q == SW'(ppmfd_pkg::SLOT_SAT)
			&& frame_time_q == prev_rise_q)
		else $error("frame completion did not update counter and frame time");

	// A falling edge leaves the decode state alone.
	assert property (@(posedge clk) disable iff (!arst_n)
		process && !level_s1 |=> $stable(slot_q) && $stable(prev_rise_q))
		else $error("falling edge changed decode state");

endmodule

// File: dv/testbench.sv
// Self-checking testbench for ppm_frame_decoder_core: random and directed pin-change
// streams, with a transaction-level predictor of the slot counter, channel store and frame age.
// Depends on ppmfd_pkg and the ppm_frame_decoder_core RTL.
module testbench;

	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 205;
	localparam int CYCLE_LIMIT     = 400000;

	typedef struct packed {
		logic        level;
		logic [31:0] stamp;
	} pin_event_t;

	typedef struct packed {
		logic                                          fresh;
		logic                                          done;
		ppmfd_pkg::chan_t [ppmfd_pkg::OUT_CHANS-1:0]   chans;
	} frame_result_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [ppmfd_pkg::IN_W-1:0]      s_tdata = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [ppmfd_pkg::OUT_W-1:0]     m_tdata;
	logic                            cfg_we = 1'b0;
	logic                            cfg_addr = 1'b0;
	logic [ppmfd_pkg::CFG_W-1:0]     cfg_wdata = '0;

	// Predictor state, kept at the widths of the block.
	logic [ppmfd_pkg::SYNC_W-1:0]    sync_gap = ppmfd_pkg::SYNC_GAP_RESET;
	logic [ppmfd_pkg::STALE_W-1:0]   stale_limit = ppmfd_pkg::STALE_TIMEOUT_RESET;
	logic [ppmfd_pkg::TIME_W-1:0]    last_rise_us = '0;
	logic [ppmfd_pkg::SLOT_W-1:0]    slot_count = '0;
	ppmfd_pkg::chan_t                chan_val [ppmfd_pkg::NUM_CHANNELS] = '{default: '0};
	logic [ppmfd_pkg::TIME_W-1:0]    frame_stamp = '0;

	pin_event_t         pin_queue [$];
	frame_result_t      results_due [$];
	pin_event_t         pin_in_flight;

	int unsigned        send_idle_pct = 0;
	int unsigned        recv_stall_pct = 0;
	int unsigned        error_count = 0;
	int unsigned        cycle_count = 0;
	int unsigned        queued_count = 0;
	logic [31:0]        gen_rise = '0;

	ppm_frame_decoder_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	task automatic flag_error(input string msg);
		error_count++;
		if (error_count <= 10) begin
			$display("%s", msg);
		end
	endtask

	// Applies one pin change to the predictor and queues the result it must produce.
	task automatic predict_edge(input pin_event_t ev);
		logic [31:0] interval;
		logic [31:0] age;
		frame_result_t r;
		r.done = 1'b0;
		if (ev.level) begin
			interval = ev.stamp - last_rise_us;
			last_rise_us = ev.stamp;
			if (interval > {16'd0, sync_gap}) begin
				slot_count = '0;
			end else if (slot_count >= 1 && slot_count <= ppmfd_pkg::NUM_CHANNELS) begin
				chan_val[slot_count - 1'b1] = interval[ppmfd_pkg::CHAN_W-1:0];
				if (slot_count == ppmfd_pkg::NUM_CHANNELS) begin
					frame_stamp = ev.stamp;
					r.done = 1'b1;
				end
			end
			if (slot_count < ppmfd_pkg::SLOT_SAT) begin
				slot_count = slot_count + 1'b1;
			end
		end
		age = ev.stamp - frame_stamp;
		for (int j = 0; j < ppmfd_pkg::OUT_CHANS; j++) begin
			r.chans[j] = (j < ppmfd_pkg::NUM_CHANNELS) ? chan_val[j] : '0;
		end
		r.fresh = (age <= {8'd0, stale_limit});
		results_due.push_back(r);
	endtask

	task automatic check_result(input logic [ppmfd_pkg::OUT_W-1:0] word);
		frame_result_t want;
		ppmfd_pkg::chan_t got_chan;
		if (results_due.size() == 0) begin
			flag_error($sformatf("unexpected result %h", word));
		end else begin
			want = results_due.pop_front();
			for (int j = 0; j < ppmfd_pkg::OUT_CHANS; j++) begin
				got_chan = word[j*ppmfd_pkg::CHAN_W +: ppmfd_pkg::CHAN_W];
				if (got_chan !== want.chans[j]) begin
					flag_error($sformatf("chan%0d_us mismatch: expected %0d, got %0d",
						j, want.chans[j], got_chan));
				end
			end
			if (word[ppmfd_pkg::OUT_CHANS*ppmfd_pkg::CHAN_W] !== want.done) begin
				flag_error($sformatf("frame_done mismatch: expected %0b, got %0b",
					want.done, word[ppmfd_pkg::OUT_CHANS*ppmfd_pkg::CHAN_W]));
			end
			if (word[ppmfd_pkg::OUT_CHANS*ppmfd_pkg::CHAN_W+1] !== want.fresh) begin
				flag_error($sformatf("frame_fresh mismatch: expected %0b, got %0b",
					want.fresh, word[ppmfd_pkg::OUT_CHANS*ppmfd_pkg::CHAN_W+1]));
			end
		end
	endtask

	// Pin-change driver: predicts each transaction as it is accepted.
	always @(posedge clk) begin : pin_driver
		pin_event_t ev;
		logic busy;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			busy = s_tvalid;
			if (s_tvalid && s_tready) begin
				predict_edge(pin_in_flight);
				busy = 1'b0;
			end
			if (!busy) begin
				if (pin_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					ev = pin_queue.pop_front();
					pin_in_flight = ev;
					s_tdata <= {{(ppmfd_pkg::IN_W-ppmfd_pkg::IN_BITS){1'b0}},
						ev.stamp, ev.level};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_result(m_tdata);
			end
			m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic push_edge(input logic level, input logic [31:0] stamp);
		pin_event_t ev;
		ev.level = level;
		ev.stamp = stamp;
		pin_queue.push_back(ev);
		queued_count++;
		if (level) begin
			gen_rise = stamp;
		end
	endtask

	// A rising edge a given interval after the last one, optionally with a
	// falling edge somewhere inside that interval.
	task automatic queue_rise(input logic [31:0] interval, input bit with_fall);
		if (with_fall) begin
			push_edge(1'b0, gen_rise + $urandom_range(interval, 0));
		end
		push_edge(1'b1, gen_rise + interval);
	endtask

	task automatic queue_frame(input int pulses, input bit with_falls);
		logic [31:0] gap;
		logic [31:0] width;
		gap = sync_gap + 32'd1 + (($urandom_range(3, 0) == 0) ? 0 : $urandom_range(20000, 0));
		queue_rise(gap, with_falls);
		for (int k = 0; k < pulses; k++) begin
			case ($urandom_range(9, 0))
				0: width = 0;
				1: width = sync_gap;
				default: width = $urandom_range(sync_gap, sync_gap / 4);
			endcase
			queue_rise(width, with_falls);
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pin_queue.size() != 0 || s_tvalid || results_due.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	// The register is written while cfg_we is held; nothing is in flight then.
	task automatic write_reg(input ppmfd_pkg::cfg_reg_t idx,
		input logic [ppmfd_pkg::CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == ppmfd_pkg::REG_SYNC_GAP) begin
			sync_gap = value[ppmfd_pkg::SYNC_W-1:0];
		end else begin
			stale_limit = value[ppmfd_pkg::STALE_W-1:0];
		end
	endtask

	initial begin : stimulus
		int roll;
		logic [31:0] done_at;
		logic [31:0] new_gap;
		logic [31:0] new_stale;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		for (int phase = 0; phase < PHASES; phase++) begin
			wait_drained();
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
				default: begin send_idle_pct = 32; recv_stall_pct = 32; end
			endcase
			case (phase)
				1: begin new_gap = 32'd65535; new_stale = 32'h00FF_FFFF; end
				2: begin new_gap = 32'd0; new_stale = 32'd0; end
				3: begin new_gap = 32'd2500; new_stale = 32'd20000; end
				4: begin new_gap = 32'd1; new_stale = 32'd1; end
				6: begin
					new_gap = 32'(ppmfd_pkg::SYNC_GAP_RESET);
					new_stale = 32'(ppmfd_pkg::STALE_TIMEOUT_RESET);
				end
				default: begin
					new_gap = $urandom_range(20000, 100);
					new_stale = $urandom_range(24'hFFFFFF, 1000);
				end
			endcase
			// The first phase runs on the reset values of both registers.
			if (phase != 0) begin
				write_reg(ppmfd_pkg::REG_SYNC_GAP, new_gap[ppmfd_pkg::CFG_W-1:0]);
				write_reg(ppmfd_pkg::REG_STALE_TIMEOUT, new_stale[ppmfd_pkg::CFG_W-1:0]);
			end
			queued_count = 0;
			if (phase == 0) begin
				// Falling edge and a zero interval right after reset.
				push_edge(1'b0, 32'd0);
				push_edge(1'b1, 32'd0);
				// A frame with an interval equal to the sync gap, and zero and one.
				queue_rise(1000, 1'b0);
				queue_rise(5000, 1'b0);
				queue_rise(0, 1'b0);
				queue_rise(1, 1'b0);
				queue_rise(1500, 1'b0);
				queue_rise(2000, 1'b0);
				done_at = gen_rise;
				// The slot counter is saturated now, so these store nothing.
				queue_rise(1000, 1'b0);
				queue_rise(700, 1'b0);
				push_edge(1'b0, done_at + 500000);
				push_edge(1'b0, done_at + 500001);
				queue_rise(5001, 1'b0);
				repeat (ppmfd_pkg::NUM_CHANNELS) queue_rise(5000, 1'b0);
				// A frame that straddles the timestamp wrap.
				push_edge(1'b1, 32'hFFFF_FFF0);
				queue_rise(32'h20, 1'b0);
				repeat (ppmfd_pkg::NUM_CHANNELS - 1) queue_rise(1234, 1'b0);
				push_edge(1'b0, 32'hFFFF_FFFF);
			end
			while (queued_count < ITEMS_PER_PHASE) begin
				roll = $urandom_range(99, 0);
				if (roll < 62) begin
					queue_frame(ppmfd_pkg::NUM_CHANNELS, 1'($urandom_range(1, 0)));
				end else if (roll < 72) begin
					queue_frame($urandom_range(ppmfd_pkg::NUM_CHANNELS - 1, 0),
						1'($urandom_range(1, 0)));
				end else if (roll < 82) begin
					queue_frame($urandom_range(ppmfd_pkg::NUM_CHANNELS + 3,
						ppmfd_pkg::NUM_CHANNELS + 1), 1'($urandom_range(1, 0)));
				end else if (roll < 90) begin
					// Age checks at the timeout or one past it, then at a random age up to twice it plus two.
					queue_frame(ppmfd_pkg::NUM_CHANNELS, 1'b0);
					push_edge(1'b0, gen_rise + stale_limit + $urandom_range(1, 0));
					push_edge(1'b0, gen_rise + $urandom_range(2 * stale_limit + 2, 0));
				end else begin
					repeat ($urandom_range(3, 1)) begin
						push_edge(1'($urandom_range(1, 0)), $urandom());
					end
				end
			end
		end
		wait_drained();
		repeat (8) @(negedge clk);
		if (results_due.size() != 0) begin
			flag_error($sformatf("%0d results never arrived", results_due.size()));
		end
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
